/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge outside reset
`define VSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define VSA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vsa_pkg.sv */
package vsa_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int OP_W        = 3;
    localparam int SLOT_W      = 6;
    localparam int VER_W       = 16;
    localparam int POOL_W      = 16;
    localparam int LIVE_W      = 7;
    localparam int ST_W        = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic REG_POOL_ID = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC       = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_QUERY       = 3'd2,
        OP_MARK        = 3'd3,
        OP_MARK_ALL    = 3'd4,
        OP_REL_MARKED  = 3'd5,
        OP_REL_ALL     = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic               handle;
        logic [SLOT_W-1:0]  slot;
        logic [VER_W-1:0]   ver;
        logic               live;
        logic               last;
    } t_res;

    function automatic t_res mk_res(t_status st, logic hnd, logic [SLOT_W-1:0] slot,
                                    logic [VER_W-1:0] ver, logic live, logic last);
        t_res r;
        r.status = st;
        r.handle = hnd;
        r.slot   = hnd ? slot : '0;
        r.ver    = hnd ? ver : '0;
        r.live   = live;
        r.last   = last;
        return r;
    endfunction

endpackage

/* rtl/vsa_ver_ram.sv */
module vsa_ver_ram
    import vsa_pkg::*;
#(
    parameter int DEPTH = SLOTS_DEF,
    parameter int AW    = $clog2(SLOTS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VER_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VER_W-1:0] o_rdata
);

    logic [VER_W-1:0] r_mem [DEPTH];
    logic [VER_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/versioned_slot_allocator.sv */
// Versioned slot allocator: a pool of SLOTS slots handed out as handles
// (pool id, slot, version). Requests arrive on the s-side stream, one beat
// each (opcode in tuser); results leave on the m-side stream, status in
// tuser, tlast on the final beat of each request's run. pool_id is set
// through the APB port; writing it only while the block is idle is a rule
// for the user, which the block itself does not enforce. Every request is
// served by one sequencer that walks slots one at a time against a simple
// dual-port version RAM (one write port, one read port) with registered
// read (read, then on release write back the incremented version). Mark,
// mark all, full allocate and bad requests answer without a RAM read;
// release and query read the handle's slot; allocate scans to the lowest
// free slot and reads its version; release marked and release all scan the
// slots in order, freeing each marked (for release all: occupied) slot.
// s_tready is high only while the sequencer is idle. Results go through
// a one-beat output register; a stalled receiver stalls the sequencer,
// nothing is dropped. Reset empties the pool, clears all marks, zeroes
// every version (through per-slot valid bits) and pool_id, and empties
// the output register. No clearing pass is needed.
module versioned_slot_allocator
    import vsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // slot_index[5:0], handle_version[21:6]
    input  logic [OP_W-1:0]        i_s_tuser,   // opcode[2:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // out_pool[15:0], out_slot[21:16],
                                                // out_version[37:22], is_live[38],
                                                // live_count[45:39]
    output logic [ST_W-1:0]        o_m_tuser,   // status[1:0]
    output logic                   o_m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC_SCAN, S_ALLOC_RD, S_HND_RD,
        S_REL_SCAN, S_REL_RD, S_ALL_SCAN, S_ALL_RD, S_SEND
    } t_state;

    t_state              r_state, n_state, r_after, n_after;
    t_op                 r_op, n_op;
    logic [VER_W-1:0]    r_ver, n_ver;
    logic [IW-1:0]       r_idx, n_idx;
    logic [SLOTS-1:0]    r_occ, n_occ, r_dm, n_dm, r_vv, n_vv;
    logic [CW-1:0]       r_count, n_count;
    logic                r_any, n_any;
    t_res                r_res, n_res;
    logic                r_rd_vld;
    logic [POOL_W-1:0]   r_pool;
    logic                r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [ST_W-1:0]     r_m_tuser, n_m_tuser;
    logic                r_m_tlast, n_m_tlast;

    logic [SLOT_W-1:0]   in_slot;
    logic [IW-1:0]       in_idx;
    logic                in_rng;
    logic [IW-1:0]       raddr;
    logic                we;
    logic [VER_W-1:0]    rd_data, ver_rd, wdata;
    logic                can_load, live, more;
    logic [SLOTS-1:0]    above;
    logic                cfg_wr;

    assign in_slot = i_s_tdata[SLOT_W-1:0];
    assign in_idx  = in_slot[IW-1:0];
    assign in_rng  = {1'b0, in_slot} < (SLOT_W + 1)'(SLOTS);
    assign ver_rd  = r_rd_vld ? rd_data : '0;
    assign wdata   = ver_rd + VER_W'(1);
    assign can_load = !r_m_valid || i_m_tready;
    assign live    = r_occ[r_idx] && (ver_rd == r_ver);
    assign above   = ({SLOTS{1'b1}} << r_idx) << 1;
    assign more    = |(r_dm & r_occ & above);

    vsa_ver_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ver_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_op      = r_op;
        n_ver     = r_ver;
        n_idx     = r_idx;
        n_occ     = r_occ;
        n_dm      = r_dm;
        n_vv      = r_vv;
        n_count   = r_count;
        n_any     = r_any;
        n_res     = r_res;
        raddr     = r_idx;
        we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                raddr = in_idx;
                if (i_s_tvalid) begin
                    n_op    = t_op'(i_s_tuser);
                    n_ver   = i_s_tdata[SLOT_W +: VER_W];
                    n_idx   = in_idx;
                    n_any   = 1'b0;
                    n_after = S_IDLE;
                    n_state = S_SEND;
                    n_res   = mk_res(ST_STALE, 1'b0, '0, '0, 1'b0, 1'b1);
                    case (t_op'(i_s_tuser))
                        OP_ALLOC: begin
                            if (r_count == CW'(SLOTS)) begin
                                n_res = mk_res(ST_FULL, 1'b0, '0, '0, 1'b0, 1'b1);
                            end else begin
                                n_idx   = '0;
                                n_state = S_ALLOC_SCAN;
                            end
                        end
                        OP_RELEASE, OP_QUERY: begin
                            if (in_rng) begin
                                n_state = S_HND_RD;
                            end
                        end
                        OP_MARK: begin
                            if (in_rng && r_occ[in_idx]) begin
                                n_dm[in_idx] = 1'b1;
                                n_res = mk_res(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
                            end
                        end
                        OP_MARK_ALL: begin
                            n_dm  = r_dm | r_occ;
                            n_res = mk_res(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                        OP_REL_MARKED: begin
                            n_idx   = '0;
                            n_state = S_REL_SCAN;
                        end
                        OP_REL_ALL: begin
                            n_idx   = '0;
                            n_any   = (r_count != '0);
                            n_state = S_ALL_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_ALLOC_SCAN: begin
                if (!r_occ[r_idx]) begin
                    n_state = S_ALLOC_RD;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_ALLOC_RD: begin
                n_occ[r_idx] = 1'b1;
                n_dm[r_idx]  = 1'b0;
                n_count      = r_count + CW'(1);
                n_res   = mk_res(ST_OK, 1'b1, SLOT_W'(r_idx), ver_rd, 1'b0, 1'b1);
                n_after = S_IDLE;
                n_state = S_SEND;
            end
            S_HND_RD: begin
                n_after = S_IDLE;
                n_state = S_SEND;
                if (r_op == OP_QUERY) begin
                    n_res = mk_res(live ? ST_OK : ST_STALE, 1'b0, '0, '0, live, 1'b1);
                end else if (live) begin
                    we           = 1'b1;
                    n_vv[r_idx]  = 1'b1;
                    n_occ[r_idx] = 1'b0;
                    n_dm[r_idx]  = 1'b0;
                    n_count      = r_count - CW'(1);
                    n_res = mk_res(ST_OK, 1'b1, SLOT_W'(r_idx), ver_rd, 1'b0, 1'b1);
                end else begin
                    n_res = mk_res(ST_STALE, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            S_REL_SCAN: begin
                if (r_dm[r_idx] && r_occ[r_idx]) begin
                    n_state = S_REL_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_dm    = '0;
                    n_res   = mk_res(ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
                    n_after = S_IDLE;
                    n_state = S_SEND;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_REL_RD: begin
                we           = 1'b1;
                n_vv[r_idx]  = 1'b1;
                n_occ[r_idx] = 1'b0;
                n_dm[r_idx]  = 1'b0;
                n_count      = r_count - CW'(1);
                n_res   = mk_res(ST_OK, 1'b1, SLOT_W'(r_idx), ver_rd, 1'b0, !more);
                n_state = S_SEND;
                if (more) begin
                    n_idx   = r_idx + IW'(1);
                    n_after = S_REL_SCAN;
                end else begin
                    n_dm    = '0;
                    n_after = S_IDLE;
                end
            end
            S_ALL_SCAN: begin
                if (r_occ[r_idx]) begin
                    n_state = S_ALL_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_dm    = '0;
                    n_res   = mk_res(r_any ? ST_OK : ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
                    n_after = S_IDLE;
                    n_state = S_SEND;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_ALL_RD: begin
                we           = 1'b1;
                n_vv[r_idx]  = 1'b1;
                n_occ[r_idx] = 1'b0;
                n_dm[r_idx]  = 1'b0;
                n_count      = r_count - CW'(1);
                if (r_idx == LAST_IDX) begin
                    n_dm    = '0;
                    n_res   = mk_res(r_any ? ST_OK : ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
                    n_after = S_IDLE;
                    n_state = S_SEND;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_ALL_SCAN;
                end
            end
            S_SEND: begin
                if (can_load) begin
                    n_state = r_after;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_tdata = r_m_tdata;
        n_m_tuser = r_m_tuser;
        n_m_tlast = r_m_tlast;
        if (r_state == S_SEND && can_load) begin
            n_m_valid = 1'b1;
            n_m_tdata = {2'b00, LIVE_W'(r_count), r_res.live, r_res.ver, r_res.slot,
                         r_res.handle ? r_pool : POOL_W'(0)};
            n_m_tuser = r_res.status;
            n_m_tlast = r_res.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_ver     <= n_ver;
        r_idx     <= n_idx;
        r_any     <= n_any;
        r_res     <= n_res;
        r_after   <= n_after;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
        r_m_tlast <= n_m_tlast;
        r_rd_vld  <= r_vv[raddr];
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_dm      <= '0;
            r_vv      <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
            r_pool    <= '0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_dm      <= n_dm;
            r_vv      <= n_vv;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (cfg_wr) begin
                r_pool <= pwdata[POOL_W-1:0];
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_ID);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL_ID) ? APB_DW'(r_pool) : '0;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

`include "assert_macros.svh"

    `VSA_ASSERT(a_count_matches, $countones(r_occ) == int'(r_count), "live count mismatch")
    `VSA_ASSERT(a_marks_on_live, (r_dm & ~r_occ) == '0, "mark on a free slot")
    `VSA_ASSERT_IMPL(a_alloc_room, r_state == S_ALLOC_SCAN, r_count < CW'(SLOTS), "scan on full")
    `VSA_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "not busy")

endmodule

/* tb/vsa_checker.sv */
`timescale 1ns / 1ps

module vsa_checker
    import vsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [IN_TDATA_W-1:0]    i_s_tdata,   // slot_index[5:0], handle_version[21:6]
    input  logic [OP_W-1:0]          i_s_tuser,   // opcode[2:0]
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [OUT_TDATA_W-1:0]   i_m_tdata,   // out_pool[15:0], out_slot[21:16],
                                                  // out_version[37:22], is_live[38],
                                                  // live_count[45:39]
    input  logic [ST_W-1:0]          i_m_tuser,   // status[1:0]
    input  logic                     i_m_tlast,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [APB_AW-1:0]        i_paddr,
    input  logic [APB_DW-1:0]        i_pwdata,
    input  logic                     i_pready,
    output int                       o_errors,
    output int                       o_outstanding,
    output logic [SLOTS-1:0]         o_occupied,
    output logic [SLOTS*VER_W-1:0]   o_versions
);

    localparam logic [APB_AW-1:0] POOL_ID_ADDR = APB_AW'(4 * int'(REG_POOL_ID));

    typedef struct packed {
        t_status            status;
        logic [POOL_W-1:0]  pool;
        logic [SLOT_W-1:0]  slot;
        logic [VER_W-1:0]   ver;
        logic               live;
        logic [LIVE_W-1:0]  count;
        logic               last;
    } t_reply;

    logic [SLOTS-1:0]   occupied_q;
    logic [SLOTS-1:0]   marked_q;
    logic [VER_W-1:0]   slot_ver [SLOTS];
    logic [LIVE_W-1:0]  n_live;
    logic [POOL_W-1:0]  pool_id_cfg;
    t_reply             pending_replies [$];
    int                 n_fail;

    function automatic void push_reply(t_status st, logic hnd, logic [SLOT_W-1:0] slot,
                                       logic [VER_W-1:0] ver, logic live, logic last);
        t_reply r;
        r.status = st;
        r.pool   = hnd ? pool_id_cfg : '0;
        r.slot   = hnd ? slot : '0;
        r.ver    = hnd ? ver : '0;
        r.live   = live;
        r.count  = n_live;
        r.last   = last;
        pending_replies.push_back(r);
    endfunction

    function automatic void free_slot(int i);
        occupied_q[i] = 1'b0;
        slot_ver[i]   = slot_ver[i] + 1'b1;
        marked_q[i]   = 1'b0;
        if (n_live != 0)
            n_live = n_live - 1'b1;
    endfunction

    function automatic void serve_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx,
                                          logic [VER_W-1:0] ver);
        logic             inr;
        logic             hit;
        logic             any;
        logic [VER_W-1:0] old;
        int               n;
        inr = int'(idx) < SLOTS;
        hit = inr && occupied_q[idx] && (slot_ver[idx] == ver);
        case (op)
            OP_ALLOC: begin
                n = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!occupied_q[i] && n < 0)
                        n = i;
                if (n >= 0) begin
                    occupied_q[n] = 1'b1;
                    marked_q[n]   = 1'b0;
                    n_live        = n_live + 1'b1;
                    push_reply(ST_OK, 1'b1, SLOT_W'(n), slot_ver[n], 1'b0, 1'b1);
                end else begin
                    push_reply(ST_FULL, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_RELEASE: begin
                if (hit) begin
                    old = slot_ver[idx];
                    free_slot(int'(idx));
                    push_reply(ST_OK, 1'b1, idx, old, 1'b0, 1'b1);
                end else begin
                    push_reply(ST_STALE, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_QUERY: push_reply(hit ? ST_OK : ST_STALE, 1'b0, '0, '0, hit, 1'b1);
            OP_MARK: begin
                if (inr && occupied_q[idx]) begin
                    marked_q[idx] = 1'b1;
                    push_reply(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    push_reply(ST_STALE, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_MARK_ALL: begin
                if (n_live != 0)
                    marked_q = marked_q | occupied_q;
                push_reply(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
            end
            OP_REL_MARKED: begin
                n = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (marked_q[i] && occupied_q[i]) begin
                        old = slot_ver[i];
                        free_slot(i);
                        push_reply(ST_OK, 1'b1, SLOT_W'(i), old, 1'b0, 1'b0);
                        n++;
                    end
                    marked_q[i] = 1'b0;
                end
                if (n == 0)
                    push_reply(ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
                else
                    pending_replies[pending_replies.size()-1].last = 1'b1;
            end
            OP_REL_ALL: begin
                any = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (occupied_q[i]) begin
                        any           = 1'b1;
                        occupied_q[i] = 1'b0;
                        slot_ver[i]   = slot_ver[i] + 1'b1;
                    end
                end
                marked_q = '0;
                n_live   = '0;
                push_reply(any ? ST_OK : ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
            end
            default: push_reply(ST_STALE, 1'b0, '0, '0, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic void check_beat();
        t_reply got;
        t_reply want;
        got.status = t_status'(i_m_tuser);
        got.pool   = i_m_tdata[15:0];
        got.slot   = i_m_tdata[21:16];
        got.ver    = i_m_tdata[37:22];
        got.live   = i_m_tdata[38];
        got.count  = i_m_tdata[45:39];
        got.last   = i_m_tlast;
        if (pending_replies.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: extra beat st=%0d pool=%h slot=%0d ver=%h live=%b cnt=%0d last=%b",
                         $realtime, got.status, got.pool, got.slot, got.ver, got.live,
                         got.count, got.last);
            return;
        end
        want = pending_replies.pop_front();
        if (got.status != want.status || got.pool != want.pool || got.slot != want.slot ||
            got.ver != want.ver || got.live != want.live || got.count != want.count ||
            got.last != want.last) begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: exp %0d %h %0d %h %b %0d %b, got %0d %h %0d %h %b %0d %b",
                         $realtime, want.status, want.pool, want.slot, want.ver, want.live,
                         want.count, want.last, got.status, got.pool, got.slot, got.ver,
                         got.live, got.count, got.last);
        end
    endfunction

    initial begin
        n_fail        = 0;
        o_errors      = 0;
        o_outstanding = 0;
        occupied_q    = '0;
        marked_q      = '0;
        n_live        = '0;
        pool_id_cfg   = '0;
        o_occupied    = '0;
        o_versions    = '0;
        for (int i = 0; i < SLOTS; i++)
            slot_ver[i] = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            occupied_q  = '0;
            marked_q    = '0;
            n_live      = '0;
            pool_id_cfg = '0;
            for (int i = 0; i < SLOTS; i++)
                slot_ver[i] = '0;
            pending_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_beat();
            if (i_s_tvalid && i_s_tready)
                serve_request(i_s_tuser, i_s_tdata[5:0], i_s_tdata[21:6]);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == POOL_ID_ADDR)
                pool_id_cfg = i_pwdata[POOL_W-1:0];
        end
        o_errors      = n_fail;
        o_outstanding = pending_replies.size();
        o_occupied    = occupied_q;
        for (int i = 0; i < SLOTS; i++)
            o_versions[i*VER_W +: VER_W] = slot_ver[i];
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import vsa_pkg::*;

    localparam int              SLOTS           = SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_UNDEF        = 3'd7;
    localparam logic [APB_AW-1:0] POOL_ID_ADDR  = APB_AW'(4 * int'(REG_POOL_ID));
    localparam int              WATCHDOG_CYCLES = 1_500_000;
    localparam int              HOLD_CYCLES     = 400;
    localparam int              DRAIN_CYCLES    = 2 * SLOTS + 20;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic [OP_W-1:0]          s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic [ST_W-1:0]          m_tuser;
    logic                     m_tlast;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int                       n_errors;
    int                       n_outstanding;
    logic [SLOTS-1:0]         live_slots;
    logic [SLOTS*VER_W-1:0]   live_versions;

    int                       send_idle_pct;
    int                       recv_stall_pct;
    bit                       hold_req;
    bit                       hold_done;

    versioned_slot_allocator #(.SLOTS(SLOTS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    vsa_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_errors      (n_errors),
        .o_outstanding (n_outstanding),
        .o_occupied    (live_slots),
        .o_versions    (live_versions)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                            input logic [VER_W-1:0] ver);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-SLOT_W-VER_W){1'b0}}, ver, idx};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random_req();
        int               roll;
        int               picks [$];
        logic [SLOT_W-1:0] idx;
        logic [VER_W-1:0]  ver;
        roll = $urandom_range(99);
        idx  = SLOT_W'($urandom);
        ver  = VER_W'($urandom);
        for (int i = 0; i < SLOTS; i++)
            if (live_slots[i])
                picks.push_back(i);
        if (picks.size() > 0 && $urandom_range(3) != 0) begin
            idx = SLOT_W'(picks[$urandom_range(picks.size() - 1)]);
            ver = live_versions[idx*VER_W +: VER_W];
            if ($urandom_range(7) == 0)
                ver = ver + 1'b1;
        end
        if (roll < 32)
            send_req(OP_ALLOC, SLOT_W'($urandom), VER_W'($urandom));
        else if (roll < 52)
            send_req(OP_RELEASE, idx, ver);
        else if (roll < 66)
            send_req(OP_QUERY, idx, ver);
        else if (roll < 76)
            send_req(OP_MARK, idx, VER_W'($urandom));
        else if (roll < 80)
            send_req(OP_MARK_ALL, SLOT_W'($urandom), VER_W'($urandom));
        else if (roll < 88)
            send_req(OP_REL_MARKED, SLOT_W'($urandom), VER_W'($urandom));
        else if (roll < 91)
            send_req(OP_REL_ALL, SLOT_W'($urandom), VER_W'($urandom));
        else
            send_req(OP_W'($urandom_range(7)), SLOT_W'($urandom), VER_W'($urandom));
    endtask

    task automatic fill_and_sweep();
        repeat (SLOTS + 2) send_req(OP_ALLOC, SLOT_W'($urandom), VER_W'($urandom));
        send_req(OP_MARK_ALL, SLOT_W'($urandom), VER_W'($urandom));
        send_req(OP_REL_MARKED, SLOT_W'($urandom), VER_W'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (n_outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_pool_id(input logic [POOL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_ID_ADDR;
        pwdata  <= {{(APB_DW-POOL_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_pool_id(16'hFFFF);
        send_req(OP_RELEASE, 6'd0, 16'h0000);
        send_req(OP_QUERY, 6'd63, 16'hFFFF);
        send_req(OP_MARK, 6'd5, 16'h0000);
        send_req(OP_MARK_ALL, 6'd0, 16'h0000);
        send_req(OP_REL_MARKED, 6'd0, 16'h0000);
        send_req(OP_REL_ALL, 6'd0, 16'h0000);
        send_req(OP_UNDEF, 6'd63, 16'hFFFF);
        repeat (3) send_req(OP_ALLOC, 6'd0, 16'h0000);
        send_req(OP_QUERY, 6'd1, 16'h0000);
        send_req(OP_RELEASE, 6'd1, 16'hFFFF);
        send_req(OP_RELEASE, 6'd1, 16'h0000);
        send_req(OP_RELEASE, 6'd1, 16'h0000);
        send_req(OP_ALLOC, 6'd63, 16'hFFFF);
        send_req(OP_MARK, 6'd2, 16'h0000);
        send_req(OP_REL_MARKED, 6'd0, 16'h0000);
        send_req(OP_MARK_ALL, 6'd0, 16'h0000);
        send_req(OP_REL_MARKED, 6'd0, 16'h0000);
        repeat (2) send_req(OP_ALLOC, 6'd0, 16'h0000);
        send_req(OP_QUERY, 6'd63, 16'h0000);
        send_req(OP_REL_ALL, 6'd0, 16'h0000);
        send_req(OP_REL_ALL, 6'd0, 16'h0000);
        settle();

        // no idling; reach the full pool
        write_pool_id(16'h0000);
        fill_and_sweep();
        repeat (50) send_random_req();
        settle();

        // sender idles
        write_pool_id(POOL_W'($urandom));
        send_idle_pct = 68;
        repeat (50) send_random_req();
        settle();

        // receiver stalls, with one long hold-off while requests keep coming
        write_pool_id(16'h8001);
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        hold_req       = 1'b1;
        send_req(OP_REL_ALL, SLOT_W'($urandom), VER_W'($urandom));
        fill_and_sweep();
        repeat (50) send_random_req();
        settle();

        // both sides idle
        write_pool_id(POOL_W'($urandom));
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        repeat (50) send_random_req();

        s_tvalid <= 1'b0;
        while (n_outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0 && n_outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
